// ===== design/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;
    localparam int ADDR_W = 32;
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NULL    = 3'd1;
    localparam logic [2:0] ST_OOM     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } chunk_t;
endpackage
`default_nettype wire

// ===== design/first_fit_heap_allocator_top.sv =====
// Channel   | Handshake           | Payload
// ----------+---------------------+--------------------------------------
// request   | s_valid / s_ready   | s_opcode, s_req_size, s_req_addr
// result    | m_valid / m_ready   | m_chunk_addr, m_status, m_reused
// config    | cfg_we              | cfg_index, cfg_wdata
// One request at a time through a sequencer over two chunk tables, each with one write
// port and a registered read port; each table step is a read state then an act state.
// Alloc, N entries per table (N <= 64): coalesce, then a first-fit scan; on a hit, removal
// of the chosen chunk, a sorted used insert and a sorted spare insert of any tail; else
// heap growth and one sorted used insert. Free: lookup, spare insert, then used removal.
// Reset clears counts and presets heap top and limit; a finished result waits for m_ready.
`default_nettype none
module first_fit_heap_allocator_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_opcode,
    input  wire logic [ffha_pkg::ADDR_W-1:0] s_req_size,
    input  wire logic [ffha_pkg::ADDR_W-1:0] s_req_addr,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ffha_pkg::ADDR_W-1:0]      m_chunk_addr,
    output logic [2:0]                       m_status,
    output logic                             m_reused,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [ffha_pkg::ADDR_W-1:0] cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_FREE_RD, S_FREE_CHK, S_CO_RD, S_CO_CHK, S_FIT_RD, S_FIT_CHK,
        S_INS_RD, S_INS_CHK, S_RM_RD, S_RM_WR, S_DISPATCH, S_EMIT
    } state_t;

    typedef enum logic [1:0] {C_EMIT, C_USED_INS, C_TAIL_INS, C_USED_RM} cont_t;

    localparam logic TAB_USED  = 1'b0;
    localparam logic TAB_SPARE = 1'b1;
    localparam int   AW        = ffha_pkg::ADDR_W;
    localparam int   CW        = ffha_pkg::CNT_W;
    localparam int   IW        = ffha_pkg::IDX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(ffha_pkg::DEPTH);

    state_t state_reg;
    cont_t  cont_reg;

    ffha_pkg::chunk_t used_mem  [ffha_pkg::DEPTH];
    ffha_pkg::chunk_t spare_mem [ffha_pkg::DEPTH];
    ffha_pkg::chunk_t used_q_reg, spare_q_reg, q;

    logic [CW-1:0] used_cnt_reg, spare_cnt_reg, idx_reg, k_reg, found_reg, tab_cnt;
    logic          tab_reg;
    logic [AW-1:0] size_reg, addr_reg, top_reg, grown_reg, limit_reg;
    logic [AW-1:0] ins_s_reg, ins_n_reg, fit_s_reg, fit_n_reg, cur_s_reg, cur_n_reg;
    logic [AW-1:0] res_addr_reg;
    logic [2:0]    res_status_reg;
    logic          res_reused_reg;
    logic          m_valid_reg;
    logic [AW-1:0] m_addr_reg;
    logic [2:0]    m_status_reg;
    logic          m_reused_reg;

    logic              we, wtab;
    logic [IW-1:0]     waddr, raddr;
    ffha_pkg::chunk_t  wdata;
    logic [AW:0]       cur_end;
    logic              adj, heap_oom;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_chunk_addr = m_addr_reg;
    assign m_status     = m_status_reg;
    assign m_reused     = m_reused_reg;

    assign q        = (tab_reg == TAB_SPARE) ? spare_q_reg : used_q_reg;
    assign tab_cnt  = (tab_reg == TAB_SPARE) ? spare_cnt_reg : used_cnt_reg;
    assign cur_end  = {1'b0, cur_s_reg} + {1'b0, cur_n_reg};
    assign adj      = (k_reg != '0) && !cur_end[AW] && (cur_end[AW-1:0] == q.start);
    assign heap_oom = (top_reg > limit_reg) || (size_reg > (limit_reg - top_reg));

    // pick read address for the next table access
    always_comb begin
        case (state_reg)
            S_INS_RD: raddr = IW'(idx_reg - 1'b1);
            S_RM_RD:  raddr = IW'(idx_reg + 1'b1);
            default:  raddr = idx_reg[IW-1:0];
        endcase
    end

    // table write strobe
    always_comb begin
        we    = 1'b0;
        wtab  = tab_reg;
        waddr = idx_reg[IW-1:0];
        wdata = '{start: ins_s_reg, size: ins_n_reg};
        case (state_reg)
            S_INS_RD: begin
                we = (idx_reg == '0);
            end
            S_INS_CHK: begin
                we = 1'b1;
                if (ins_s_reg < q.start) wdata = q;
            end
            S_RM_WR: begin
                we    = 1'b1;
                wdata = q;
            end
            S_CO_RD: begin
                we    = (idx_reg >= spare_cnt_reg) && (k_reg != '0);
                wtab  = TAB_SPARE;
                waddr = IW'(k_reg - 1'b1);
                wdata = '{start: cur_s_reg, size: cur_n_reg};
            end
            S_CO_CHK: begin
                we    = !adj && (k_reg != '0);
                wtab  = TAB_SPARE;
                waddr = IW'(k_reg - 1'b1);
                wdata = '{start: cur_s_reg, size: cur_n_reg};
            end
            default: we = 1'b0;
        endcase
    end

    // chunk tables with registered reads
    always_ff @(posedge aclk) begin
        if (we && wtab == TAB_USED)  used_mem[waddr]  <= wdata;
        if (we && wtab == TAB_SPARE) spare_mem[waddr] <= wdata;
        used_q_reg  <= used_mem[raddr];
        spare_q_reg <= spare_mem[raddr];
    end

    // sequencer, heap state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cont_reg      <= C_EMIT;
            used_cnt_reg  <= '0;
            spare_cnt_reg <= '0;
            top_reg       <= AW'(32'd4096);
            grown_reg     <= '0;
            limit_reg     <= AW'(32'd1048576);
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_EMIT) m_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_we) begin
                if (cfg_index == ffha_pkg::CFG_BASE) begin
                    if (grown_reg == '0) top_reg <= cfg_wdata;
                end else begin
                    limit_reg <= cfg_wdata;
                end
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        size_reg       <= s_req_size;
                        addr_reg       <= s_req_addr;
                        idx_reg        <= '0;
                        k_reg          <= '0;
                        res_addr_reg   <= '0;
                        res_reused_reg <= 1'b0;
                        res_status_reg <= ffha_pkg::ST_NULL;
                        cont_reg       <= C_EMIT;
                        if (s_opcode == ffha_pkg::OP_FREE) begin
                            tab_reg   <= TAB_USED;
                            state_reg <= (s_req_addr == '0) ? S_EMIT : S_FREE_RD;
                        end else begin
                            tab_reg   <= TAB_SPARE;
                            state_reg <= (s_req_size == '0) ? S_EMIT : S_CO_RD;
                        end
                    end
                end
                // look up the chunk to free
                S_FREE_RD: begin
                    if (idx_reg < used_cnt_reg) begin
                        state_reg <= S_FREE_CHK;
                    end else begin
                        res_status_reg <= ffha_pkg::ST_UNKNOWN;
                        state_reg      <= S_EMIT;
                    end
                end
                S_FREE_CHK: begin
                    if (q.start == addr_reg) begin
                        if (spare_cnt_reg >= FULL_CNT) begin
                            res_status_reg <= ffha_pkg::ST_FULL;
                            state_reg      <= S_EMIT;
                        end else begin
                            res_status_reg <= ffha_pkg::ST_OK;
                            found_reg      <= idx_reg;
                            ins_s_reg      <= q.start;
                            ins_n_reg      <= q.size;
                            tab_reg        <= TAB_SPARE;
                            idx_reg        <= spare_cnt_reg;
                            cont_reg       <= C_USED_RM;
                            state_reg      <= S_INS_RD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FREE_RD;
                    end
                end
                // merge touching spare chunks, compacting in place
                S_CO_RD: begin
                    if (idx_reg < spare_cnt_reg) begin
                        state_reg <= S_CO_CHK;
                    end else begin
                        spare_cnt_reg <= k_reg;
                        idx_reg       <= '0;
                        if (used_cnt_reg >= FULL_CNT) begin
                            res_status_reg <= ffha_pkg::ST_FULL;
                            state_reg      <= S_EMIT;
                        end else begin
                            state_reg <= S_FIT_RD;
                        end
                    end
                end
                S_CO_CHK: begin
                    if (adj) begin
                        cur_n_reg <= cur_n_reg + q.size;
                    end else begin
                        cur_s_reg <= q.start;
                        cur_n_reg <= q.size;
                        k_reg     <= k_reg + 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_CO_RD;
                end
                // first-fit scan, else extend the heap top
                S_FIT_RD: begin
                    if (idx_reg < spare_cnt_reg) begin
                        state_reg <= S_FIT_CHK;
                    end else if (heap_oom) begin
                        res_status_reg <= ffha_pkg::ST_OOM;
                        state_reg      <= S_EMIT;
                    end else begin
                        res_status_reg <= ffha_pkg::ST_OK;
                        res_addr_reg   <= top_reg;
                        top_reg        <= top_reg + size_reg;
                        grown_reg      <= grown_reg + size_reg;
                        ins_s_reg      <= top_reg;
                        ins_n_reg      <= size_reg;
                        tab_reg        <= TAB_USED;
                        idx_reg        <= used_cnt_reg;
                        state_reg      <= S_INS_RD;
                    end
                end
                S_FIT_CHK: begin
                    if (q.size >= size_reg) begin
                        res_status_reg <= ffha_pkg::ST_OK;
                        res_addr_reg   <= q.start;
                        res_reused_reg <= 1'b1;
                        fit_s_reg      <= q.start;
                        fit_n_reg      <= q.size;
                        cont_reg       <= C_USED_INS;
                        state_reg      <= S_RM_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_FIT_RD;
                    end
                end
                // sorted insert: shift larger starts up one slot
                S_INS_RD: begin
                    if (idx_reg == '0) begin
                        if (tab_reg == TAB_SPARE) spare_cnt_reg <= spare_cnt_reg + 1'b1;
                        else                      used_cnt_reg  <= used_cnt_reg + 1'b1;
                        state_reg <= S_DISPATCH;
                    end else begin
                        state_reg <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    if (ins_s_reg < q.start) begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end else begin
                        if (tab_reg == TAB_SPARE) spare_cnt_reg <= spare_cnt_reg + 1'b1;
                        else                      used_cnt_reg  <= used_cnt_reg + 1'b1;
                        state_reg <= S_DISPATCH;
                    end
                end
                // remove: shift later entries down one slot
                S_RM_RD: begin
                    if ((idx_reg + 1'b1) < tab_cnt) begin
                        state_reg <= S_RM_WR;
                    end else begin
                        if (tab_reg == TAB_SPARE) spare_cnt_reg <= spare_cnt_reg - 1'b1;
                        else                      used_cnt_reg  <= used_cnt_reg - 1'b1;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_RM_WR: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_RM_RD;
                end
                // advance to the next table operation of this item
                S_DISPATCH: begin
                    case (cont_reg)
                        C_USED_INS: begin
                            ins_s_reg <= fit_s_reg;
                            ins_n_reg <= size_reg;
                            tab_reg   <= TAB_USED;
                            idx_reg   <= used_cnt_reg;
                            cont_reg  <= C_TAIL_INS;
                            state_reg <= S_INS_RD;
                        end
                        C_TAIL_INS: begin
                            cont_reg <= C_EMIT;
                            if (fit_n_reg != size_reg) begin
                                ins_s_reg <= fit_s_reg + size_reg;
                                ins_n_reg <= fit_n_reg - size_reg;
                                tab_reg   <= TAB_SPARE;
                                idx_reg   <= spare_cnt_reg;
                                state_reg <= S_INS_RD;
                            end else begin
                                state_reg <= S_EMIT;
                            end
                        end
                        C_USED_RM: begin
                            tab_reg   <= TAB_USED;
                            idx_reg   <= found_reg;
                            cont_reg  <= C_EMIT;
                            state_reg <= S_RM_RD;
                        end
                        default: state_reg <= S_EMIT;
                    endcase
                end
                // hand the result over once the output stage is free
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_addr_reg   <= res_addr_reg;
                        m_status_reg <= res_status_reg;
                        m_reused_reg <= res_reused_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
